### rtl/assert_macros.svh
// Assertion macros shared by the altitude controller RTL.
// No dependencies; each macro reduces to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/altpd_pkg.sv
// Types and constants of the altitude PD controller core.
// No dependencies; used by altitude_pd_controller_core by scoped names.
package altpd_pkg;

	// flight modes carried on the input tuser
	typedef enum logic [1:0] {
		KIND_NORMAL  = 2'd0,
		KIND_REMOTE  = 2'd1,
		KIND_TAKEOFF = 2'd2,
		KIND_LANDING = 2'd3
	} kind_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BOUND = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GPS_MODE     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 8'd3;

	// reset values of the configuration registers
	localparam logic [9:0]  BOUND_RST  = 10'd100;
	localparam logic        GPS_RST    = 1'b1;
	localparam logic [15:0] GAIN_P_RST = 16'd256;
	localparam logic [15:0] GAIN_D_RST = 16'd256;

	// target height limits (23 bit signed range) at 25 bit working width
	localparam logic signed [24:0] TGT_HI = 25'sd4194303;
	localparam logic signed [24:0] TGT_LO = -25'sd4194304;

	// speed error limit in cm/s at 18 bit working width
	localparam logic signed [17:0] VEL_HI = 18'sd100;
	localparam logic signed [17:0] VEL_LO = -18'sd100;

	// integral window and limits, cm in Q.8
	localparam logic [17:0]        WIN_Q8  = 18'd12800;
	localparam logic signed [19:0] SUM1_HI = 20'sd25600;
	localparam logic signed [19:0] SUM1_LO = -20'sd25600;
	localparam logic signed [19:0] SUM2_HI = 20'sd38400;
	localparam logic signed [19:0] SUM2_LO = -20'sd38400;

	// floor(y / 5) = (y * RECIP5) >> RECIP5_SH for any 32 bit y
	localparam logic [31:0] RECIP5    = 32'hCCCC_CCCD;
	localparam int unsigned RECIP5_SH = 34;

endpackage

### rtl/altitude_pd_controller_core.sv
// Altitude PD controller core: three register stages from tick beat to result beat.
// Depends on altpd_pkg and assert_macros.svh.
//
// Usage
//   One control tick enters per beat on the s_axis channel: the flight mode on
//   s_axis_tuser, the heights and speeds packed in s_axis_tdata. Each tick gives
//   one result beat on m_axis: control_out, height_error, integral_error and
//   target_height_mm. The first tick after reset latches the reference height.
//   Registers are written by the user on the cfg channel (always ready) while no
//   tick is in flight (unenforced): 0 height bound, 1 gps mode, 2 gain P, 3 gain D.
// Timing
//   A tick passes registers s1, s2 and s3 from input beat to result beat, and
//   one is accepted every cycle unless m_axis_tready stalls: stage one builds
//   the target, the height error magnitude (constant reciprocal multiply) and
//   the D term; stage two clamps the error, updates the integral and applies
//   gain P; closing the integral loop there sets the one tick per cycle rate.
// Reset and stall
//   Reset empties the pipeline, clears the reference latch and the integral,
//   and loads the register defaults. When m_axis_tready is low the result is
//   held; s_axis_tready drops only once all three stages hold ticks.
`include "assert_macros.svh"

module altitude_pd_controller_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// tick input
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [20:0] ground_height_mm, [41:21] height_offset_mm, [62:42] current_height_mm,
	// [77:63] vertical_vel_cms, [95:78] track_height_cm, [116:96] mode_height_mm,
	// [131:117] mode_vel_cms, [146:132] route_vel_cms, [164:147] target_offset_mm,
	// [179:165] vel_offset_cms, [183:180] zero
	input  logic [183:0]                s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                  s_axis_tuser,
	// result output
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [31:0] control_out, [50:32] height_error, [67:51] integral_error,
	// [90:68] target_height_mm, [95:91] zero
	output logic [95:0]                 m_axis_tdata,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [altpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                 cfg_data
);

	// configuration registers
	logic [9:0]  bound_q;
	logic        gps_q;
	logic [15:0] gain_p_q;
	logic [15:0] gain_d_q;

	// controller state
	logic signed [21:0] ref_height_q;
	logic               first_done_q;
	logic signed [16:0] error_sum_q;

	// stage 1: captured tick
	logic                    valid_s1;
	altpd_pkg::kind_t        kind_s1;
	logic signed [20:0]      ground_s1;
	logic signed [20:0]      hoff_s1;
	logic signed [20:0]      cur_s1;
	logic signed [14:0]      vvel_s1;
	logic signed [17:0]      track_s1;
	logic signed [20:0]      mh_s1;
	logic signed [14:0]      mv_s1;
	logic signed [14:0]      rv_s1;
	logic signed [17:0]      toff_s1;
	logic signed [14:0]      voff_s1;

	// stage 2: error magnitude, sign, D term, target
	logic                    valid_s2;
	logic [27:0]             err_mag_s2;
	logic                    err_neg_s2;
	logic signed [24:0]      dprod_s2;
	logic signed [22:0]      target_s2;

	// stage 3: result
	logic                    valid_s3;
	logic signed [31:0]      ctl_s3;
	logic signed [18:0]      herr_s3;
	logic signed [16:0]      isum_s3;
	logic signed [22:0]      target_s3;

	logic en1, en2, en3;
	logic adv_a, adv_b;

	// handshake: each stage loads when empty or when its successor loads
	assign en3   = !valid_s3 || m_axis_tready;
	assign en2   = !valid_s2 || en3;
	assign en1   = !valid_s1 || en2;
	assign adv_a = valid_s1 && en2;
	assign adv_b = valid_s2 && en3;

	assign s_axis_tready = en1;
	assign cfg_ready     = 1'b1;

	// ---------------- stage A: target, error magnitude, D term ----------------
	logic signed [21:0] ref_new;
	logic signed [21:0] ref_use;
	logic signed [21:0] track10;
	logic signed [24:0] tgt_raw;
	logic signed [22:0] tgt_sat;
	logic signed [16:0] tvel;
	logic signed [24:0] hdiff;
	logic               hdiff_neg;
	logic [23:0]        hdiff_mag;
	logic [30:0]        y_half;
	logic [63:0]        recip_prod;
	logic signed [17:0] sv_raw;
	logic signed [7:0]  sv_c;
	logic signed [24:0] dprod;

	always_comb begin
		// reference latched from the first tick
		ref_new = 22'(hoff_s1) + (gps_q ? 22'(ground_s1) : 22'sd0);
		ref_use = first_done_q ? ref_height_q : ref_new;
		track10 = (22'(track_s1) <<< 3) + (22'(track_s1) <<< 1);

		// target height and speed by flight mode
		unique case (kind_s1)
			altpd_pkg::KIND_REMOTE: begin
				tgt_raw = 25'(ref_use) + 25'(track10) + 25'(mh_s1);
				tvel    = 17'(rv_s1) + 17'(mv_s1);
			end
			altpd_pkg::KIND_TAKEOFF: begin
				tgt_raw = 25'(ref_use) + 25'(mh_s1);
				tvel    = 17'(mv_s1);
			end
			altpd_pkg::KIND_LANDING: begin
				tgt_raw = 25'(ref_use) + 25'(track10) - 25'(mh_s1);
				tvel    = -17'(mv_s1);
			end
			default: begin
				tgt_raw = 25'(ref_use) + 25'(track10);
				tvel    = 17'(rv_s1);
			end
		endcase

		// saturate target to 23 bits
		if (tgt_raw > altpd_pkg::TGT_HI)
			tgt_sat = 23'(altpd_pkg::TGT_HI);
		else if (tgt_raw < altpd_pkg::TGT_LO)
			tgt_sat = 23'(altpd_pkg::TGT_LO);
		else
			tgt_sat = 23'(tgt_raw);

		// height difference in mm, split into sign and magnitude
		hdiff     = 25'(tgt_sat) + (gps_q ? 25'(toff_s1) : 25'sd0) - 25'(cur_s1);
		hdiff_neg = hdiff[24];
		hdiff_mag = hdiff_neg ? 24'(-hdiff) : 24'(hdiff);

		// round(|d| * 256 / 10) = floor((|d| * 128 + 2) / 5)
		y_half     = {hdiff_mag, 7'd0} + 31'd2;
		recip_prod = 64'(y_half) * 64'(altpd_pkg::RECIP5);

		// speed error, saturated to +-100 cm/s, then D term in cm units
		sv_raw = 18'(vvel_s1) - 18'(tvel) + 18'(voff_s1);
		if (sv_raw > altpd_pkg::VEL_HI)
			sv_c = 8'(altpd_pkg::VEL_HI);
		else if (sv_raw < altpd_pkg::VEL_LO)
			sv_c = 8'(altpd_pkg::VEL_LO);
		else
			sv_c = 8'(sv_raw);
		dprod = $signed({9'd0, gain_d_q}) * 25'(sv_c);
	end

	// ---------------- stage B: clamp, integral, P term ----------------
	logic [17:0]        bound_q8;
	logic [17:0]        mag_c;
	logic signed [18:0] err;
	logic               in_window;
	logic signed [19:0] sum_a;
	logic signed [19:0] sum_b;
	logic signed [19:0] sum_c;
	logic signed [19:0] sum_pre;
	logic signed [16:0] sum_next;
	logic signed [35:0] pprod;
	logic signed [31:0] ctl;

	always_comb begin
		// clamp error magnitude to the bound, then restore sign
		bound_q8 = {bound_q, 8'd0};
		mag_c    = (err_mag_s2 > 28'(bound_q8)) ? bound_q8 : 18'(err_mag_s2);
		err      = err_neg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

		// windowed integral: add, clamp to 100 cm, add again
		in_window = mag_c < altpd_pkg::WIN_Q8;
		sum_a     = 20'(error_sum_q) + 20'(err);
		if (sum_a > altpd_pkg::SUM1_HI)
			sum_b = altpd_pkg::SUM1_HI;
		else if (sum_a < altpd_pkg::SUM1_LO)
			sum_b = altpd_pkg::SUM1_LO;
		else
			sum_b = sum_a;
		sum_c   = sum_b + 20'(err);
		sum_pre = in_window ? sum_c : 20'(error_sum_q);

		// outer clamp to 150 cm
		if (sum_pre > altpd_pkg::SUM2_HI)
			sum_next = 17'(altpd_pkg::SUM2_HI);
		else if (sum_pre < altpd_pkg::SUM2_LO)
			sum_next = 17'(altpd_pkg::SUM2_LO);
		else
			sum_next = 17'(sum_pre);

		// P term in Q.16, floor to Q.8, minus D term; never exceeds 32 bits
		pprod = $signed({1'b0, gain_p_q}) * 36'(err);
		ctl   = 32'($signed(pprod[35:8])) - 32'(dprod_s2);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q  <= altpd_pkg::BOUND_RST;
			gps_q    <= altpd_pkg::GPS_RST;
			gain_p_q <= altpd_pkg::GAIN_P_RST;
			gain_d_q <= altpd_pkg::GAIN_D_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				altpd_pkg::CFG_HEIGHT_BOUND: bound_q  <= cfg_data[9:0];
				altpd_pkg::CFG_GPS_MODE:     gps_q    <= cfg_data[0];
				altpd_pkg::CFG_GAIN_P:       gain_p_q <= cfg_data;
				altpd_pkg::CFG_GAIN_D:       gain_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// controller state: reference latch and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_height_q <= '0;
			first_done_q <= 1'b0;
			error_sum_q  <= '0;
		end else begin
			if (adv_a && !first_done_q) begin
				ref_height_q <= ref_new;
				first_done_q <= 1'b1;
			end
			if (adv_b)
				error_sum_q <= sum_next;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= s_axis_tvalid;
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				valid_s3 <= valid_s2;
		end
	end

	// capture the input beat
	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1   <= altpd_pkg::kind_t'(s_axis_tuser);
			ground_s1 <= s_axis_tdata[20:0];
			hoff_s1   <= s_axis_tdata[41:21];
			cur_s1    <= s_axis_tdata[62:42];
			vvel_s1   <= s_axis_tdata[77:63];
			track_s1  <= s_axis_tdata[95:78];
			mh_s1     <= s_axis_tdata[116:96];
			mv_s1     <= s_axis_tdata[131:117];
			rv_s1     <= s_axis_tdata[146:132];
			toff_s1   <= s_axis_tdata[164:147];
			voff_s1   <= s_axis_tdata[179:165];
		end
	end

	// advance stage A results
	always_ff @(posedge clk) begin
		if (en2) begin
			err_mag_s2 <= recip_prod[altpd_pkg::RECIP5_SH +: 28];
			err_neg_s2 <= hdiff_neg;
			dprod_s2   <= dprod;
			target_s2  <= tgt_sat;
		end
	end

	// hold the result beat
	always_ff @(posedge clk) begin
		if (en3) begin
			ctl_s3    <= ctl;
			herr_s3   <= err;
			isum_s3   <= sum_next;
			target_s3 <= target_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {5'd0, target_s3, isum_s3, herr_s3, ctl_s3};

	// integral never leaves its outer limit
	`ASSERT_PROP(a_sum_range, clk, arst_n,
		(error_sum_q <= 17'sd38400) && (error_sum_q >= -17'sd38400))
	// reference latch is set once and stays set
	`ASSERT_PROP(a_first_sticky, clk, arst_n, first_done_q |=> first_done_q)
	// a tick leaving stage two shows up as a result
	`ASSERT_PROP(a_adv_b_lands, clk, arst_n, adv_b |=> valid_s3)
	// a result beat never carries an error beyond the bound
	`ASSERT_NEVER(a_herr_bound, clk, arst_n,
		valid_s3 && ((herr_s3 > $signed({1'b0, bound_q, 8'd0})) ||
		(herr_s3 < -$signed({1'b0, bound_q, 8'd0}))))

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for altitude_pd_controller_core: directed and random control ticks,
// checked beat by beat against an in-bench predictor of the control law.
// Depends on altpd_pkg and the core RTL only.
module tb_top;

	localparam int CYCLE_LIMIT = 400000;

	// input tick, first declared field in the top bits so the struct maps onto tdata
	typedef struct packed {
		logic [3:0]  pad;
		logic [14:0] climb_off;
		logic [17:0] aim_off_mm;
		logic [14:0] route_climb;
		logic [14:0] mode_climb;
		logic [20:0] mode_mm;
		logic [17:0] track_cm;
		logic [14:0] climb;
		logic [20:0] height_mm;
		logic [20:0] offset_mm;
		logic [20:0] ground_mm;
	} tick_t;

	// result beat layout
	typedef struct packed {
		logic [4:0]  pad;
		logic [22:0] tgt_mm;
		logic [16:0] integ;
		logic [18:0] h_err;
		logic [31:0] cmd;
	} cmd_t;

	// Tracks the controller state and owes one command per accepted tick.
	class pd_tracker;
		logic [9:0]  bound;
		logic        gps;
		logic [15:0] gain_p;
		logic [15:0] gain_d;
		longint      ref_mm;
		bit          latched;
		longint      err_sum;
		cmd_t        pending_cmds[$];
		int          bad_count;

		function new();
			bound = altpd_pkg::BOUND_RST;
			gps = altpd_pkg::GPS_RST;
			gain_p = altpd_pkg::GAIN_P_RST;
			gain_d = altpd_pkg::GAIN_D_RST;
			ref_mm = 0;
			latched = 0;
			err_sum = 0;
			bad_count = 0;
		endfunction

		static function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(logic [altpd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				altpd_pkg::CFG_HEIGHT_BOUND: bound = val[9:0];
				altpd_pkg::CFG_GPS_MODE:     gps = val[0];
				altpd_pkg::CFG_GAIN_P:       gain_p = val;
				altpd_pkg::CFG_GAIN_D:       gain_d = val;
				default: ;
			endcase
		endfunction

		// target height (saturated) and target climb rate for a flight mode
		function void target_for(altpd_pkg::kind_t k, tick_t t, output longint tgt,
			output longint tvel);
			longint trk, mh, mv, rv;
			trk = longint'($signed(t.track_cm)) * 10;
			mh = longint'($signed(t.mode_mm));
			mv = longint'($signed(t.mode_climb));
			rv = longint'($signed(t.route_climb));
			case (k)
				altpd_pkg::KIND_REMOTE: begin
					tgt = ref_mm + trk + mh;
					tvel = rv + mv;
				end
				altpd_pkg::KIND_TAKEOFF: begin
					tgt = ref_mm + mh;
					tvel = mv;
				end
				altpd_pkg::KIND_LANDING: begin
					tgt = ref_mm + trk - mh;
					tvel = -mv;
				end
				default: begin
					tgt = ref_mm + trk;
					tvel = rv;
				end
			endcase
			tgt = clip(tgt, -4194304, 4194303);
		endfunction

		// advance the state by one tick and queue the command it owes
		function void note_tick(altpd_pkg::kind_t k, tick_t t);
			longint tgt, tvel, d, n, mag, e, lim, sv, acc;
			cmd_t c;
			if (!latched) begin
				latched = 1;
				ref_mm = clip(longint'($signed(t.offset_mm)) +
					(gps ? longint'($signed(t.ground_mm)) : longint'(0)), -2097152, 2097151);
			end
			target_for(k, t, tgt, tvel);

			// height error in cm Q.8, rounded half away from zero, then bounded
			d = tgt + (gps ? longint'($signed(t.aim_off_mm)) : longint'(0))
				- longint'($signed(t.height_mm));
			n = d * 256;
			mag = (((n < 0) ? -n : n) + 5) / 10;
			e = (n < 0) ? -mag : mag;
			lim = longint'(bound) * 256;
			e = clip(e, -lim, lim);

			// windowed integral: add twice with an inner clamp, then the outer clamp
			if (e < 12800 && e > -12800) begin
				err_sum = clip(err_sum + e, -25600, 25600) + e;
			end
			err_sum = clip(err_sum, -38400, 38400);

			sv = clip(longint'($signed(t.climb)) - tvel + longint'($signed(t.climb_off)),
				-100, 100) * 256;
			acc = longint'(gain_p) * e - longint'(gain_d) * sv;
			acc = clip(acc >>> 8, -64'sd2147483648, 64'sd2147483647);

			c.pad = '0;
			c.cmd = acc[31:0];
			c.h_err = e[18:0];
			c.integ = err_sum[16:0];
			c.tgt_mm = tgt[22:0];
			pending_cmds.push_back(c);
		endfunction

		function void complain(string what, longint want, longint got);
			bad_count++;
			if (bad_count <= 10)
				$display("%s mismatch: expected 0x%0h, got 0x%0h", what, want, got);
		endfunction

		function void check_cmd(cmd_t got);
			cmd_t want;
			if (pending_cmds.size() == 0) begin
				complain("unexpected result beat", 64'd0, 64'(got.cmd));
				return;
			end
			want = pending_cmds.pop_front();
			if (got.cmd !== want.cmd)
				complain("control_out", 64'(want.cmd), 64'(got.cmd));
			if (got.h_err !== want.h_err)
				complain("height_error", 64'(want.h_err), 64'(got.h_err));
			if (got.integ !== want.integ)
				complain("integral_error", 64'(want.integ), 64'(got.integ));
			if (got.tgt_mm !== want.tgt_mm)
				complain("target_height_mm", 64'(want.tgt_mm), 64'(got.tgt_mm));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [183:0]         s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [altpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	pd_tracker sb = new();
	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_go = 1'b0;
	int  cycles = 0;

	altitude_pd_controller_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// field value: 0 top of range, 1 bottom, 2 near zero, otherwise any bits
	function automatic longint pick(int w, int sel);
		longint lim = longint'(1) << (w - 1);
		int s = (sel < 0) ? int'($urandom_range(7)) : sel;
		case (s)
			0: return lim - 1;
			1: return -lim;
			2: return longint'(int'($urandom_range(2000)) - 1000);
			default: return longint'({$urandom, $urandom});
		endcase
	endfunction

	function automatic tick_t fill_tick(int sel);
		tick_t t;
		t.pad = '0;
		t.ground_mm = 21'(pick(21, sel));
		t.offset_mm = 21'(pick(21, sel));
		t.height_mm = 21'(pick(21, sel));
		t.climb = 15'(pick(15, sel));
		t.track_cm = 18'(pick(18, sel));
		t.mode_mm = 21'(pick(21, sel));
		t.mode_climb = 15'(pick(15, sel));
		t.route_climb = 15'(pick(15, sel));
		t.aim_off_mm = 18'(pick(18, sel));
		t.climb_off = 15'(pick(15, sel));
		return t;
	endfunction

	// place the measured height and climb a given distance from the current targets
	function automatic tick_t aim(altpd_pkg::kind_t k, tick_t t, longint dh, longint dv);
		longint tgt, tvel;
		sb.target_for(k, t, tgt, tvel);
		t.height_mm = 21'(pd_tracker::clip(tgt - dh +
			(sb.gps ? longint'($signed(t.aim_off_mm)) : longint'(0)), -1048576, 1048575));
		t.climb = 15'(pd_tracker::clip(tvel - longint'($signed(t.climb_off)) + dv,
			-16384, 16383));
		return t;
	endfunction

	// offer one tick, with random idle cycles ahead of it, and hold until taken
	task automatic send_tick(altpd_pkg::kind_t k, tick_t t);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= t;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_tick(k, t);
	endtask

	// write all four registers, one beat each
	task automatic apply_settings(logic [15:0] bound, logic [15:0] gps,
		logic [15:0] gp, logic [15:0] gd);
		logic [altpd_pkg::CFG_IDX_W-1:0] idx [4];
		logic [15:0] val [4];
		idx = '{altpd_pkg::CFG_HEIGHT_BOUND, altpd_pkg::CFG_GPS_MODE,
			altpd_pkg::CFG_GAIN_P, altpd_pkg::CFG_GAIN_D};
		val = '{bound, gps, gp, gd};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	// result side: check each beat, stall at random, one long hold-off on request
	initial begin
		int hold_ticks;
		hold_ticks = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_cmd(cmd_t'(m_axis_tdata));
			if (hold_go && hold_ticks < 400) begin
				m_axis_tready <= 1'b0;
				hold_ticks++;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// stimulus
	initial begin
		tick_t t;
		altpd_pkg::kind_t k;
		int sel;
		int dh_cases [7];
		int dv_cases [4];
		dh_cases = '{500, -500, 499, -499, 0, 1000000, -1000000};
		dv_cases = '{100, -100, 101, -101};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pick the gps mode that the reference latch sees
		apply_settings(16'(altpd_pkg::BOUND_RST), 16'($urandom_range(1)),
			16'(altpd_pkg::GAIN_P_RST), 16'(altpd_pkg::GAIN_D_RST));
		hold_go <= 1'b1;

		// first tick latches the reference: push both inputs to one end
		t = fill_tick(-1);
		sel = $urandom_range(1);
		t.ground_mm = 21'(pick(21, sel));
		t.offset_mm = 21'(pick(21, sel));
		send_tick(altpd_pkg::KIND_NORMAL, t);

		// every mode with all fields at the top, then at the bottom
		for (int s = 0; s < 2; s++)
			for (int m = 0; m < 4; m++)
				send_tick(altpd_pkg::kind_t'(m), fill_tick(s));

		// integral window edges and large errors against the bound
		foreach (dh_cases[i]) begin
			k = altpd_pkg::kind_t'($urandom_range(3));
			send_tick(k, aim(k, fill_tick(-1), longint'(dh_cases[i]), longint'(0)));
		end

		// speed error at and just past its limit
		foreach (dv_cases[i]) begin
			k = altpd_pkg::kind_t'($urandom_range(3));
			send_tick(k, aim(k, fill_tick(-1), longint'(0), longint'(dv_cases[i])));
		end
		s_axis_tvalid <= 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin idle_pct <= 0;  stall_pct <= 0;  end
				1: begin idle_pct <= 59; stall_pct <= 0;  end
				2: begin idle_pct <= 0;  stall_pct <= 59; end
				default: begin idle_pct <= 19; stall_pct <= 19; end
			endcase
			case (ph)
				0: apply_settings(16'(altpd_pkg::BOUND_RST), 16'(altpd_pkg::GPS_RST),
					16'(altpd_pkg::GAIN_P_RST), 16'(altpd_pkg::GAIN_D_RST));
				1: apply_settings(16'd1000, 16'd1, 16'hFFFF, 16'hFFFF);
				2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
				3: apply_settings(16'd1023, 16'd0, 16'd1, 16'hFFFF);
				default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			endcase

			// mostly ticks near the target so the integral and speed paths work
			for (int n = 0; n < 200; n++) begin
				k = altpd_pkg::kind_t'($urandom_range(3));
				t = fill_tick(-1);
				if ($urandom_range(3) != 0)
					t = aim(k, t,
						longint'(($urandom_range(3) == 0) ? int'($urandom_range(40000)) - 20000
							: int'($urandom_range(1600)) - 800),
						longint'(int'($urandom_range(300)) - 150));
				send_tick(k, t);
			end
			s_axis_tvalid <= 1'b0;
		end

		drain();
		repeat (6) @(posedge clk);
		if (sb.bad_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

### altitude_pd_controller_core.f
+incdir+rtl
rtl/altpd_pkg.sv
rtl/altitude_pd_controller_core.sv
test/tb_top.sv
